// ===== design/arqsw_pkg.sv =====
`default_nettype none
package arqsw_pkg;

  localparam int SEQ_WIDTH = 32;
  localparam int SIZE_WIDTH = 11;
  localparam int HANDLE_PORT_WIDTH = 16;
  localparam int WSIZE_WIDTH = 5;
  localparam logic [WSIZE_WIDTH-1:0] WINDOW_SIZE_RESET = 5'd16;

  // remainder unit takes this many dividend bits per cycle
  localparam int MOD_STEP_BITS = 8;
  localparam int MOD_CHUNKS = SEQ_WIDTH / MOD_STEP_BITS;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_FIND = 2'd1,
    ACT_ACK  = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_FIND,
    ST_ACK,
    ST_RESULT
  } state_t;

  typedef struct packed {
    action_t                        action;
    logic [SEQ_WIDTH-1:0]           seq_num;
    logic [SIZE_WIDTH-1:0]          frame_size;
    logic [HANDLE_PORT_WIDTH-1:0]   buffer_handle;
    logic [SEQ_WIDTH-1:0]           ack_seq;
  } request_t;

  typedef struct packed {
    logic                           found;
    logic [SIZE_WIDTH-1:0]          size_out;
    logic [HANDLE_PORT_WIDTH-1:0]   handle_out;
    logic [SEQ_WIDTH-1:0]           lower_out;
    logic [SEQ_WIDTH-1:0]           upper_out;
  } result_t;

  typedef struct packed {
    logic [WSIZE_WIDTH-1:0] window_size;
  } cfg_t;

endpackage
`default_nettype wire

// ===== design/arqsw_stream_if.sv =====
`default_nettype none
interface arqsw_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/arqsw_ram.sv =====
`default_nettype none
module arqsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/arqsw_mod.sv =====
`default_nettype none
// sequence number modulo window size, a few dividend bits per cycle
module arqsw_mod #(
  parameter int WINDOW_DEPTH = 16,
  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
  localparam int NW = $clog2(WINDOW_DEPTH + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic [arqsw_pkg::SEQ_WIDTH-1:0]     dividend,
  input  wire logic [NW-1:0]                       divisor,
  output logic                                     done,
  output logic      [AW-1:0]                       rem
);
  localparam int CW = (arqsw_pkg::MOD_CHUNKS > 1) ? $clog2(arqsw_pkg::MOD_CHUNKS) : 1;

  logic                              busy;
  logic [CW-1:0]                     cnt;
  logic [arqsw_pkg::SEQ_WIDTH-1:0]   sh;
  logic [NW-1:0]                     acc;
  logic [NW-1:0]                     acc_next;
  logic [NW:0]                       trial;

  // restoring remainder steps, acc stays below divisor
  always_comb begin
    acc_next = acc;
    trial = '0;
    for (int k = 0; k < arqsw_pkg::MOD_STEP_BITS; k++) begin
      trial = {acc_next, sh[arqsw_pkg::SEQ_WIDTH-1-k]};
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      acc_next = trial[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(arqsw_pkg::MOD_CHUNKS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= dividend;
      acc <= '0;
      cnt <= '0;
    end else if (busy) begin
      sh  <= sh << arqsw_pkg::MOD_STEP_BITS;
      acc <= acc_next;
      cnt <= cnt + CW'(1);
    end
  end

  assign rem = AW'(acc);
endmodule
`default_nettype wire

// ===== design/arq_send_window_buffer.sv =====
`default_nettype none
// Selective-repeat send window. An item is taken only while the block is idle and its result
// leaves through one output register. An add or a find first starts the remainder unit from a
// register, which then turns the sequence number into a slot at eight sequence bits per cycle;
// an add then writes the slot memory and a find reads it and takes the read data in a state of
// its own, and then the result register is loaded. Acknowledge walks the slots in use one memory
// read per cycle before its result is loaded; the unused action code goes straight to the result
// register. The block returns to idle as the result is loaded, so the next item can be taken
// while that result still waits; a result the receiver has not taken holds the next result back.
// Slot contents live in one memory; the valid marks are flops and come up cleared after reset.
// Configuration writes are always accepted and must only be made while the block is idle.
module arq_send_window_buffer #(
  parameter int WINDOW_DEPTH = 16,
  parameter int HANDLE_WIDTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  arqsw_stream_if.sink    request,
  arqsw_stream_if.sink    cfg,
  arqsw_stream_if.source  result
);
  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int NW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = arqsw_pkg::SEQ_WIDTH;
  localparam int ZW = arqsw_pkg::SIZE_WIDTH;
  localparam int EW = SW + ZW + HANDLE_WIDTH;
  localparam int RESET_SIZE = (int'(arqsw_pkg::WINDOW_SIZE_RESET) > WINDOW_DEPTH) ?
                              WINDOW_DEPTH : int'(arqsw_pkg::WINDOW_SIZE_RESET);

  arqsw_pkg::state_t                      state;
  arqsw_pkg::state_t                      state_next;
  arqsw_pkg::request_t                    item;
  arqsw_pkg::result_t                     out_data;

  logic [arqsw_pkg::WSIZE_WIDTH-1:0]      window_size;
  logic [NW-1:0]                          n;
  logic [WINDOW_DEPTH-1:0]                valid;
  logic [SW-1:0]                          lower;
  logic [SW-1:0]                          upper;
  logic                                   out_valid;
  logic                                   out_load;

  logic [AW-1:0]                          idx;
  logic [NW-1:0]                          wi;
  logic                                   chk_pend;
  logic [AW-1:0]                          chk_idx;

  logic                                   res_found;
  logic [ZW-1:0]                          res_size;
  logic [arqsw_pkg::HANDLE_PORT_WIDTH-1:0] res_handle;

  logic                                   mod_start;
  logic                                   mod_start_q;
  logic                                   mod_done;
  logic [AW-1:0]                          mod_rem;

  logic                                   ram_we;
  logic [AW-1:0]                          ram_raddr;
  logic [EW-1:0]                          ram_wdata;
  logic [EW-1:0]                          ram_rdata;
  logic [SW-1:0]                          rd_seq;
  logic [ZW-1:0]                          rd_size;
  logic [HANDLE_WIDTH-1:0]                rd_handle;
  logic                                   ack_end;

  assign cfg.ready = 1'b1;

  // slots in use, clamped to 1..depth
  always_comb begin
    if (window_size == '0) begin
      n = NW'(1);
    end else if (int'(window_size) > WINDOW_DEPTH) begin
      n = NW'(WINDOW_DEPTH);
    end else begin
      n = NW'(window_size);
    end
  end

  arqsw_mod #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (item.seq_num),
    .divisor  (n),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign ram_wdata = {item.seq_num, item.frame_size, HANDLE_WIDTH'(item.buffer_handle)};
  assign {rd_seq, rd_size, rd_handle} = ram_rdata;

  arqsw_ram #(
    .WIDTH (EW),
    .DEPTH (WINDOW_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (mod_rem),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ack_end = (wi == n) && !chk_pend;
  assign out_load = (state == arqsw_pkg::ST_RESULT) && (!out_valid || result.ready);
  assign request.ready = (state == arqsw_pkg::ST_IDLE);
  assign result.valid = out_valid;
  assign result.payload = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arqsw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_raddr  = wi[AW-1:0];
    unique case (state)
      arqsw_pkg::ST_IDLE: begin
        if (request.valid) begin
          unique case (request.payload.action)
            arqsw_pkg::ACT_ADD,
            arqsw_pkg::ACT_FIND: state_next = arqsw_pkg::ST_MOD;
            arqsw_pkg::ACT_ACK:  state_next = arqsw_pkg::ST_ACK;
            arqsw_pkg::ACT_NONE: state_next = arqsw_pkg::ST_RESULT;
          endcase
        end
      end
      arqsw_pkg::ST_MOD: begin
        ram_raddr = mod_rem;
        if (mod_done) begin
          if (item.action == arqsw_pkg::ACT_ADD) begin
            ram_we     = 1'b1;
            state_next = arqsw_pkg::ST_RESULT;
          end else begin
            state_next = arqsw_pkg::ST_FIND;
          end
        end
      end
      arqsw_pkg::ST_FIND: state_next = arqsw_pkg::ST_RESULT;
      arqsw_pkg::ST_ACK: begin
        if (ack_end) begin
          state_next = arqsw_pkg::ST_RESULT;
        end
      end
      arqsw_pkg::ST_RESULT: begin
        if (out_load) begin
          state_next = arqsw_pkg::ST_IDLE;
        end
      end
      default: state_next = arqsw_pkg::ST_IDLE;
    endcase
  end

  // remainder unit starts in the cycle after the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      mod_start_q <= 1'b0;
    end else begin
      mod_start_q <= request.valid && request.ready &&
                     (request.payload.action == arqsw_pkg::ACT_ADD ||
                      request.payload.action == arqsw_pkg::ACT_FIND);
    end
  end

  assign mod_start = mod_start_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= arqsw_pkg::WINDOW_SIZE_RESET;
      valid       <= '0;
      lower       <= '0;
      upper       <= SW'(RESET_SIZE);
      out_valid   <= 1'b0;
      chk_pend    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        window_size <= cfg.payload.window_size;
      end
      if (state == arqsw_pkg::ST_MOD && mod_done &&
          item.action == arqsw_pkg::ACT_ADD) begin
        valid[mod_rem] <= 1'b1;
      end
      if (state == arqsw_pkg::ST_ACK) begin
        chk_pend <= (wi != n);
        // empty slots are left alone
        if (chk_pend && valid[chk_idx] && rd_seq < item.ack_seq) begin
          valid[chk_idx] <= 1'b0;
        end
        if (ack_end && lower < item.ack_seq) begin
          lower <= item.ack_seq;
          upper <= item.ack_seq + SW'(n);
        end
      end else begin
        chk_pend <= 1'b0;
      end
      out_valid <= out_load || (out_valid && !result.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      item       <= request.payload;
      wi         <= '0;
      res_found  <= 1'b0;
      res_size   <= '0;
      res_handle <= '0;
    end
    if (state == arqsw_pkg::ST_MOD && mod_done) begin
      idx <= mod_rem;
    end
    if (state == arqsw_pkg::ST_FIND && valid[idx]) begin
      res_found  <= 1'b1;
      res_size   <= rd_size;
      res_handle <= arqsw_pkg::HANDLE_PORT_WIDTH'(rd_handle);
    end
    if (state == arqsw_pkg::ST_ACK && wi != n) begin
      chk_idx <= wi[AW-1:0];
      wi      <= wi + NW'(1);
    end
    if (out_load) begin
      out_data.found      <= res_found;
      out_data.size_out   <= res_size;
      out_data.handle_out <= res_handle;
      out_data.lower_out  <= lower;
      out_data.upper_out  <= upper;
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/arq_send_window_buffer_tb.sv =====
`default_nettype none
module arq_send_window_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_DEPTH = 16;
  localparam int HANDLE_WIDTH = 16;
  localparam logic [arqsw_pkg::HANDLE_PORT_WIDTH-1:0] HANDLE_MASK =
    16'((1 << HANDLE_WIDTH) - 1);
  localparam int N_DIR = 26;
  localparam int N_PHASES = 11;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int SETTLE_CYCLES = 24;

  localparam arqsw_pkg::result_t AFTER_RST = '{1'b0, 11'd0, 16'd0, 32'd0, 32'd16};
  localparam logic [arqsw_pkg::WSIZE_WIDTH-1:0] SIZE_PLAN [8] = '{
    5'd0, 5'd1, 5'd31, 5'd16, 5'd7, 5'd17, 5'd3, 5'd12
  };

  typedef struct {
    arqsw_pkg::request_t req;
    bit                  typed;
    arqsw_pkg::result_t  want;
  } stim_row_t;

  logic clk;
  logic rst;

  arqsw_stream_if #(.payload_t(arqsw_pkg::request_t)) req_if ();
  arqsw_stream_if #(.payload_t(arqsw_pkg::cfg_t))     cfg_if ();
  arqsw_stream_if #(.payload_t(arqsw_pkg::result_t))  res_if ();

  arq_send_window_buffer #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .HANDLE_WIDTH(HANDLE_WIDTH)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .request(req_if),
    .cfg    (cfg_if),
    .result (res_if)
  );

  // the first sixteen rows fill every slot so no slot is ever read before it is written
  stim_row_t dir_rows [N_DIR] = '{
    '{'{arqsw_pkg::ACT_ADD, 32'h0000_0000, 11'd2047, 16'hffff, 32'hffff_ffff}, 1'b1, AFTER_RST},
    '{'{arqsw_pkg::ACT_ADD, 32'hffff_ffff, 11'd0, 16'h0000, 32'h0000_0000}, 1'b1, AFTER_RST},
    '{'{arqsw_pkg::ACT_ADD, 32'h0000_0001, 11'h555, 16'haaaa, 32'h0000_0000}, 1'b1, AFTER_RST},
    '{'{arqsw_pkg::ACT_ADD, 32'h0000_0002, 11'h2aa, 16'h5555, 32'h0000_0000}, 1'b1, AFTER_RST},
    '{'{arqsw_pkg::ACT_ADD, 32'h0000_0003, 11'd3, 16'h0003, 32'h0000_0000}, 1'b1, AFTER_RST},
    '{'{arqsw_pkg::ACT_ADD, 32'h0000_0004, 11'd4, 16'h0004, 32'h0000_0000}, 1'b1, AFTER_RST},
    '{'{arqsw_pkg::ACT_ADD, 32'h0000_0005, 11'd5, 16'h0005, 32'h0000_0000}, 1'b1, AFTER_RST},
    '{'{arqsw_pkg::ACT_ADD, 32'h0000_0006, 11'd6, 16'h0006, 32'h0000_0000}, 1'b1, AFTER_RST},
    '{'{arqsw_pkg::ACT_ADD, 32'h0000_0007, 11'd7, 16'h0007, 32'h0000_0000}, 1'b1, AFTER_RST},
    '{'{arqsw_pkg::ACT_ADD, 32'h0000_0008, 11'd8, 16'h0008, 32'h0000_0000}, 1'b1, AFTER_RST},
    '{'{arqsw_pkg::ACT_ADD, 32'h0000_0009, 11'd9, 16'h0009, 32'h0000_0000}, 1'b1, AFTER_RST},
    '{'{arqsw_pkg::ACT_ADD, 32'h0000_000a, 11'd10, 16'h000a, 32'h0000_0000}, 1'b1, AFTER_RST},
    '{'{arqsw_pkg::ACT_ADD, 32'h0000_000b, 11'd11, 16'h000b, 32'h0000_0000}, 1'b1, AFTER_RST},
    '{'{arqsw_pkg::ACT_ADD, 32'h0000_000c, 11'd12, 16'h000c, 32'h0000_0000}, 1'b1, AFTER_RST},
    '{'{arqsw_pkg::ACT_ADD, 32'h0000_000d, 11'd13, 16'h000d, 32'h0000_0000}, 1'b1, AFTER_RST},
    '{'{arqsw_pkg::ACT_ADD, 32'h0000_000e, 11'd14, 16'h000e, 32'h0000_0000}, 1'b1, AFTER_RST},
    '{'{arqsw_pkg::ACT_FIND, 32'h0000_0000, 11'd0, 16'h0000, 32'h0000_0000}, 1'b1,
      '{1'b1, 11'd2047, 16'hffff, 32'd0, 32'd16}},
    '{'{arqsw_pkg::ACT_FIND, 32'hffff_ffff, 11'd0, 16'h0000, 32'h0000_0000}, 1'b1,
      '{1'b1, 11'd0, 16'h0000, 32'd0, 32'd16}},
    // slot 0 again under another sequence number
    '{'{arqsw_pkg::ACT_FIND, 32'h0000_0010, 11'd0, 16'h0000, 32'h0000_0000}, 1'b0, '0},
    '{'{arqsw_pkg::ACT_ACK, 32'h0000_0000, 11'd0, 16'h0000, 32'h0000_0000}, 1'b0, '0},
    '{'{arqsw_pkg::ACT_ACK, 32'h0000_0000, 11'd0, 16'h0000, 32'h0000_0005}, 1'b0, '0},
    '{'{arqsw_pkg::ACT_FIND, 32'h0000_0003, 11'd0, 16'h0000, 32'h0000_0000}, 1'b0, '0},
    '{'{arqsw_pkg::ACT_NONE, 32'h0000_0007, 11'd2047, 16'hffff, 32'hffff_ffff}, 1'b0, '0},
    // below the lower edge and over emptied slots
    '{'{arqsw_pkg::ACT_ACK, 32'h0000_0000, 11'd0, 16'h0000, 32'h0000_0003}, 1'b0, '0},
    '{'{arqsw_pkg::ACT_ADD, 32'h0000_0014, 11'd9, 16'h1234, 32'h0000_0000}, 1'b0, '0},
    '{'{arqsw_pkg::ACT_FIND, 32'h0000_0004, 11'd0, 16'h0000, 32'h0000_0000}, 1'b0, '0}
  };

  // window model
  logic [arqsw_pkg::WSIZE_WIDTH-1:0]       win_cfg;
  logic                                    win_valid  [WINDOW_DEPTH];
  logic [arqsw_pkg::SEQ_WIDTH-1:0]         win_seq    [WINDOW_DEPTH];
  logic [arqsw_pkg::SIZE_WIDTH-1:0]        win_size   [WINDOW_DEPTH];
  logic [arqsw_pkg::HANDLE_PORT_WIDTH-1:0] win_handle [WINDOW_DEPTH];
  logic [arqsw_pkg::SEQ_WIDTH-1:0]         win_lower;
  logic [arqsw_pkg::SEQ_WIDTH-1:0]         win_upper;

  arqsw_pkg::result_t pending_results [$];
  int      mismatch_count;
  int      burst_left;
  bit      sender_steady;
  logic [15:0] stall_pat;
  int      pat_pos;
  int      pat_rounds;
  arqsw_pkg::result_t got_r;
  arqsw_pkg::result_t want_r;

  function automatic int unsigned eff_window(logic [arqsw_pkg::WSIZE_WIDTH-1:0] ws);
    if (ws == 0) return 1;
    if (ws > WINDOW_DEPTH) return WINDOW_DEPTH;
    return ws;
  endfunction

  function automatic arqsw_pkg::result_t window_step(arqsw_pkg::request_t r);
    arqsw_pkg::result_t res;
    int unsigned n;
    int unsigned idx;
    res = '0;
    n = eff_window(win_cfg);
    idx = r.seq_num % n;
    case (r.action)
      arqsw_pkg::ACT_ADD: begin
        win_valid[idx]  = 1'b1;
        win_seq[idx]    = r.seq_num;
        win_size[idx]   = r.frame_size;
        win_handle[idx] = r.buffer_handle & HANDLE_MASK;
      end
      arqsw_pkg::ACT_FIND: begin
        if (win_valid[idx]) begin
          res.found      = 1'b1;
          res.size_out   = win_size[idx];
          res.handle_out = win_handle[idx];
        end
      end
      arqsw_pkg::ACT_ACK: begin
        for (int i = 0; i < n; i++) begin
          if (win_valid[i] && win_seq[i] < r.ack_seq) win_valid[i] = 1'b0;
        end
        if (win_lower < r.ack_seq) begin
          win_lower = r.ack_seq;
          win_upper = win_lower + n;
        end
      end
      default: ;
    endcase
    res.lower_out = win_lower;
    res.upper_out = win_upper;
    return res;
  endfunction

  // mostly traffic around the lower edge, some noise with fully random fields
  function automatic arqsw_pkg::request_t next_window_request(bit jump_to_top);
    arqsw_pkg::request_t r;
    int unsigned n;
    int unsigned pick;
    n = eff_window(win_cfg);
    r.action        = arqsw_pkg::ACT_ADD;
    r.seq_num       = $urandom;
    r.frame_size    = 11'($urandom);
    r.buffer_handle = 16'($urandom);
    r.ack_seq       = $urandom;
    pick = $urandom_range(0, 99);
    if (jump_to_top) begin
      // push the edges close to the top so upper wraps later in the phase
      r.action  = arqsw_pkg::ACT_ACK;
      r.ack_seq = 32'hffff_ffc0;
    end else if (pick < 45) begin
      r.seq_num = win_lower + $urandom_range(0, 2 * n - 1);
    end else if (pick < 75) begin
      r.action  = arqsw_pkg::ACT_FIND;
      r.seq_num = win_lower - n + $urandom_range(0, 3 * n - 1);
    end else if (pick < 90) begin
      r.action  = arqsw_pkg::ACT_ACK;
      r.ack_seq = win_lower - 2 + $urandom_range(0, n + 4);
    end else if (pick < 94) begin
      r.action = arqsw_pkg::ACT_NONE;
    end else begin
      r.action = arqsw_pkg::action_t'($urandom_range(0, 3));
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_request(arqsw_pkg::request_t r, bit typed, arqsw_pkg::result_t want);
    arqsw_pkg::result_t pred;
    int gap;
    if (!sender_steady && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    req_if.valid <= 1'b1;
    req_if.payload <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pred = window_step(r);
    pending_results.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_window_size(logic [arqsw_pkg::WSIZE_WIDTH-1:0] ws);
    wait_results_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.payload <= '{window_size: ws};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    win_cfg = ws;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver stalls follow a sixteen-bit pattern that is kept for one to four rounds
  initial begin
    res_if.ready = 1'b0;
    pat_pos = 0;
    pat_rounds = 0;
    stall_pat = 16'hffff;
    forever begin
      @(negedge clk);
      if (pat_pos == 0) begin
        if (pat_rounds == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pat = 16'hffff;
            1: stall_pat = 16'($urandom);
            2: stall_pat = 16'($urandom & $urandom);
            default: stall_pat = 16'($urandom | $urandom);
          endcase
          if (stall_pat == 16'h0000) stall_pat[0] = 1'b1;
          pat_rounds = $urandom_range(1, 4);
        end
        pat_rounds--;
      end
      res_if.ready <= stall_pat[pat_pos];
      pat_pos = (pat_pos + 1) % 16;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'd0, 32'd0);
      end else begin
        want_r = pending_results.pop_front();
        got_r = res_if.payload;
        if (got_r.found !== want_r.found)
          report_mismatch("found", 32'(got_r.found), 32'(want_r.found));
        if (got_r.size_out !== want_r.size_out)
          report_mismatch("size_out", 32'(got_r.size_out), 32'(want_r.size_out));
        if (got_r.handle_out !== want_r.handle_out)
          report_mismatch("handle_out", 32'(got_r.handle_out), 32'(want_r.handle_out));
        if (got_r.lower_out !== want_r.lower_out)
          report_mismatch("lower_out", got_r.lower_out, want_r.lower_out);
        if (got_r.upper_out !== want_r.upper_out)
          report_mismatch("upper_out", got_r.upper_out, want_r.upper_out);
      end
    end
  end

  initial begin
    logic [arqsw_pkg::WSIZE_WIDTH-1:0] ws;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    rst = 1'b1;
    mismatch_count = 0;
    burst_left = 0;
    sender_steady = 1'b0;
    win_cfg = arqsw_pkg::WINDOW_SIZE_RESET;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      win_valid[i] = 1'b0;
      win_seq[i] = '0;
      win_size[i] = '0;
      win_handle[i] = '0;
    end
    win_lower = '0;
    win_upper = eff_window(arqsw_pkg::WINDOW_SIZE_RESET);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 8) ws = SIZE_PLAN[ph];
      else if (ph < N_PHASES - 1) ws = 5'($urandom_range(0, 31));
      else ws = 5'd16;
      write_window_size(ws);
      sender_steady = (ph % 3 == 1);
      burst_left = 0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++)
        send_request(next_window_request(ph == N_PHASES - 1 && k == 0), 1'b0, '0);
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/arqsw_pkg.sv
design/arqsw_stream_if.sv
design/arqsw_ram.sv
design/arqsw_mod.sv
design/arq_send_window_buffer.sv
tb/sv/arq_send_window_buffer_tb.sv
